// ----- sv/irtd_pkg.sv -----
package irtd_pkg;

  // Default operand width
  localparam int VALUE_WIDTH = 32;

  // Smallest trial divisor
  localparam int FIRST_DIVISOR = 2;

  // Handshake status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;  // unit is iterating
    logic done;  // one-cycle pulse, result registers are valid
  } unit_stat_t;

endpackage

// ----- sv/integer_radical_trial_division_top.sv -----
// Radical (product of distinct prime factors) by trial division.
// Each trial divisor costs one pass of a bit-serial divider.
// Each new prime found adds one shift-add multiply.
// Worst case (VALUE_WIDTH=32, a large prime) ~65536 divisions.
// One request at a time; in_ready is high only while the sequencer is idle.
// rst_n is synchronous, active low; it clears the sequencer, start pulses and out_valid.
module integer_radical_trial_division_top #(
  parameter int VALUE_WIDTH = irtd_pkg::VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_radical
);

  localparam int W = VALUE_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_FMUL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic         div_go_r, div_go_nxt;
  logic         mul_go_r, mul_go_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] dsr_r, dsr_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] last_r, last_nxt;
  logic [W-1:0] out_r, out_nxt;

  irtd_pkg::unit_stat_t div_stat;
  irtd_pkg::unit_stat_t mul_stat;
  logic [W-1:0]         div_quo;
  logic [W-1:0]         div_rem;
  logic [W-1:0]         mul_prod;
  logic [W-1:0]         mul_b;

  irtd_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go_r),
    .dividend  (rem_r),
    .divisor   (dsr_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Final multiply takes the leftover prime, otherwise the current divisor
  assign mul_b = (state_r == S_FMUL) ? rem_r : dsr_r;

  irtd_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .op_a  (prod_r),
    .op_b  (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_radical = out_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    div_go_nxt    = 1'b0;
    mul_go_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    prod_nxt      = prod_r;
    last_nxt      = last_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rem_nxt  = in_value;
          dsr_nxt  = W'(irtd_pkg::FIRST_DIVISOR);
          prod_nxt = W'(1);
          last_nxt = '0;
          if (in_value < W'(irtd_pkg::FIRST_DIVISOR)) begin
            state_nxt = S_DONE;
          end else begin
            div_go_nxt = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (dsr_r > div_quo) begin
            // Divisor squared exceeds remainder: leftover is 1 or a prime
            if (rem_r > W'(1) && rem_r != last_r) begin
              last_nxt   = rem_r;
              mul_go_nxt = 1'b1;
              state_nxt  = S_FMUL;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (div_rem == '0) begin
            rem_nxt = div_quo;
            if (dsr_r != last_r) begin
              last_nxt   = dsr_r;
              mul_go_nxt = 1'b1;
              state_nxt  = S_MUL;
            end else begin
              div_go_nxt = 1'b1;
            end
          end else begin
            dsr_nxt    = dsr_r + W'(1);
            div_go_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          prod_nxt   = mul_prod;
          div_go_nxt = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_FMUL: begin
        if (mul_stat.done) begin
          prod_nxt  = mul_prod;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_nxt       = prod_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_go_r    <= div_go_nxt;
      mul_go_r    <= mul_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      dsr_r  <= W'(irtd_pkg::FIRST_DIVISOR);
      prod_r <= W'(1);
      last_r <= '0;
      out_r  <= '0;
    end else begin
      rem_r  <= rem_nxt;
      dsr_r  <= dsr_nxt;
      prod_r <= prod_nxt;
      last_r <= last_nxt;
      out_r  <= out_nxt;
    end
  end

endmodule

// ----- sv/irtd_div.sv -----
module irtd_div #(
  parameter int W = irtd_pkg::VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output irtd_pkg::unit_stat_t  stat,
  output logic [W-1:0]          quotient,
  output logic [W-1:0]          remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  part_r;
  logic [W-1:0]  den_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: bring down the next dividend bit and trial-subtract
  assign shifted = {part_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = ~diff[W];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r  <= dividend;
      part_r <= '0;
      den_r  <= divisor;
    end else if (busy_r) begin
      quo_r  <= {quo_r[W-2:0], fits};
      part_r <= fits ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = part_r;

endmodule

// ----- sv/irtd_mul.sv -----
module irtd_mul #(
  parameter int W = irtd_pkg::VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [W-1:0]          op_a,
  input  logic [W-1:0]          op_b,
  output irtd_pkg::unit_stat_t  stat,
  output logic [W-1:0]          prod
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mc_r;
  logic [W-1:0]  mp_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-add, one multiplier bit per cycle, low W bits kept
  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= '0;
      mc_r  <= op_a;
      mp_r  <= op_b;
    end else if (busy_r) begin
      acc_r <= acc_r + (mp_r[0] ? mc_r : '0);
      mc_r  <= {mc_r[W-2:0], 1'b0};
      mp_r  <= {1'b0, mp_r[W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

// ----- dv/irtd_checker.sv -----
// Watches both channels of the radical unit, predicts each radical and
// compares the results in order.
module irtd_checker #(
  parameter int W = irtd_pkg::VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [W-1:0] in_value,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [W-1:0] out_radical,
  output int           mismatches,
  output int           outstanding,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Radicals owed by the block, oldest request first
  logic [W-1:0] radical_due[$];

  // Product of the distinct primes of v by trial division
  function automatic logic [W-1:0] radical_of(logic [W-1:0] v);
    logic [W-1:0] rem;
    logic [W-1:0] div;
    logic [W-1:0] prod;
    logic [W-1:0] last_p;
    rem    = v;
    div    = W'(irtd_pkg::FIRST_DIVISOR);
    prod   = W'(1);
    last_p = '0;
    if (v < W'(irtd_pkg::FIRST_DIVISOR)) return W'(1);
    // divisor squared is tested by a division so it cannot wrap
    while (div <= rem / div) begin
      if (rem % div == '0) begin
        if (div != last_p) begin
          prod   = prod * div;
          last_p = div;
        end
        rem = rem / div;
      end else begin
        div = div + W'(1);
      end
    end
    // leftover above one is a prime not yet counted
    if (rem > W'(1) && rem != last_p) prod = prod * rem;
    return prod;
  endfunction

  // Result side pops before the request side pushes: a result never
  // belongs to the request accepted at the same edge
  always @(posedge clk) begin : watch
    logic [W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (radical_due.size() == 0) begin
          $error("radical: no request outstanding, got %h", out_radical);
          mismatches++;
        end else begin
          want = radical_due.pop_front();
          if (out_radical !== want) begin
            $error("radical: expected %h, got %h", want, out_radical);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) radical_due = {radical_due, radical_of(in_value)};
    end
    outstanding = radical_due.size();
  end

endmodule

// ----- dv/tb_integer_radical_trial_division_top.sv -----
// Stimulus and verdict for the radical unit; checking lives in irtd_checker.
module tb_integer_radical_trial_division_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W          = irtd_pkg::VALUE_WIDTH;
  localparam int STEP_CAP   = 300;     // trial steps allowed for a random value
  localparam int HOLD_LEN   = 30000;   // long output stall, in cycles
  localparam int IDLE_LIMIT = 200000;  // cycles without any transfer

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] in_value;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_radical;

  int           mismatches;
  int           outstanding;
  int           results_seen;
  int           sent;
  int           directed_cnt;
  int           stall_left;
  int           idle_cycles;
  logic         in_taken;
  logic         steady;    // no gaps on either side
  logic         hold_req;  // ask the receiver for one long stall
  logic         hold_done; // receiver has served the long stall

  integer_radical_trial_division_top #(.VALUE_WIDTH(W)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_radical(out_radical)
  );

  irtd_checker #(.W(W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_radical (out_radical),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request acceptance, registered so the sender reads it at the falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Trial-division steps for v, counted no further than just past cap
  function automatic int trial_steps(logic [W-1:0] v, int cap);
    logic [W-1:0] rem;
    logic [W-1:0] div;
    int           n;
    rem = v;
    div = W'(2);
    n   = 0;
    if (v < W'(2)) return 0;
    while (div <= rem / div && n <= cap) begin
      n++;
      if (rem % div == '0) rem = rem / div;
      else div = div + W'(1);
    end
    return n;
  endfunction

  // Product of small factors, sometimes times one factor up to 10000
  function automatic logic [W-1:0] smooth_value();
    logic [63:0] acc;
    logic [63:0] f;
    int          k;
    int          i;
    acc = 1;
    k   = $urandom_range(1, 10);
    for (i = 0; i < k; i++) begin
      f = $urandom_range(2, 97);
      if (((acc * f) >> W) == 0) acc = acc * f;
    end
    if ($urandom_range(0, 1) == 1) begin
      f = $urandom_range(2, 10000);
      if (((acc * f) >> W) == 0) acc = acc * f;
    end
    return acc[W-1:0];
  endfunction

  // Random value whose factoring stays cheap enough for the run length
  function automatic logic [W-1:0] pick_value();
    logic [63:0]  acc;
    logic [63:0]  p;
    logic [W-1:0] v;
    int           sel;
    int           tries;
    sel = $urandom_range(0, 19);
    if (sel < 9) return smooth_value();
    if (sel < 15) begin
      // full-width values, kept only when factoring is short
      for (tries = 0; tries < 64; tries++) begin
        v = W'($urandom);
        if (trial_steps(v, STEP_CAP) <= STEP_CAP) return v;
      end
      return smooth_value();
    end
    if (sel < 18) return W'($urandom_range(0, 2000));
    // power of one small prime-ish base
    p   = $urandom_range(2, 13);
    acc = p;
    while (((acc * p) >> W) == 0 && $urandom_range(0, 7) != 0) acc = acc * p;
    return acc[W-1:0];
  endfunction

  // Sender gap: mostly none or short, a few long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (steady) n = 0;
    else if (r < 90 && r >= 50) n = $urandom_range(1, 3);
    else if (r >= 90) n = $urandom_range(10, 60);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one request and hold it until accepted
  task automatic send(logic [W-1:0] v);
    sender_gap();
    in_valid = 1'b1;
    in_value = v;
    sent++;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  // Stop offering until every owed radical has come back
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold on request
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1'b1;
      end else if (steady || stall_left == 0) begin
        out_ready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
        end
      end else begin
        out_ready = 1'b0;
        stall_left--;
      end
    end
  end

  initial begin
    int i;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Corners: zero, one, small primes and powers, squarefree values,
    // a leftover prime equal to the last one found, all-ones and top bit
    send(0);
    send(1);
    send(2);
    send(3);
    send(4);
    send(8);
    send(9);
    send(12);
    send(49);
    send(7919);
    send(63001);        // 251 squared
    send(65536);
    send(65537);
    send(30030);
    send(223092870);    // primes up to 23
    send(32'd3486784401); // 3 to the 20th
    send(32'd4293984256); // 2^16 times 65521
    send('1);
    send({1'b1, {(W-1){1'b0}}});
    send(32'hAAAA_AAAA);
    send(32'h5555_5555);
    send(32'hFFFF_FF00);
    directed_cnt = sent;
    drain();

    // Random traffic with a gapless stretch, a long output hold
    // and one full drain part way
    for (i = 0; i < 80; i++) begin
      if (i == 16) steady = 1'b1;
      if (i == 30) steady = 1'b0;
      if (i == 38) hold_req = 1'b1;
      if (i == 55) drain();
      send(pick_value());
    end
    drain();
    repeat (50) @(negedge clk);

    $display("%0d requests (%0d directed), %0d radicals compared",
             sent, directed_cnt, results_seen);
    $display("zero, one, prime powers, full-width values, a %0d-cycle output hold",
             HOLD_LEN);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/irtd_pkg.sv
sv/irtd_div.sv
sv/irtd_mul.sv
sv/integer_radical_trial_division_top.sv
dv/irtd_checker.sv
dv/tb_integer_radical_trial_division_top.sv
